FILE: hdl/u16u8_pkg.sv
package u16u8_pkg;

	// UTF-16 surrogate ranges
	localparam logic [15:0] HIGH_SUR_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_SUR_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_SUR_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_SUR_LAST   = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE      = 21'h10000;
	localparam logic [9:0]  SUR_BITS_MASK  = 10'h3FF;

	// UTF-8 lead and continuation marks and range limits
	localparam logic [20:0] LIMIT_ONE   = 21'h80;
	localparam logic [20:0] LIMIT_TWO   = 21'h800;
	localparam logic [20:0] LIMIT_THREE = 21'h10000;
	localparam logic [7:0]  LEAD_TWO    = 8'hC0;
	localparam logic [7:0]  LEAD_THREE  = 8'hE0;
	localparam logic [7:0]  LEAD_FOUR   = 8'hF0;
	localparam logic [7:0]  CONT_MARK   = 8'h80;
	localparam logic [5:0]  CONT_MASK   = 6'h3F;

	// most output bytes caused by one input word
	localparam int unsigned RUN_MAX = 6;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_stream;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last_of_run;
		logic       stream_done;
	} out_word_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      len;
	} enc_t;

	// a run of output bytes produced by one input word
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] b;
		logic [2:0]              cnt;
		logic                    data;
		logic                    eos;
	} run_t;

	function automatic enc_t encode_cp(input logic [20:0] cp);
		enc_t e;
		e.b = '0;
		if (cp < LIMIT_ONE) begin
			e.b[0] = {1'b0, cp[6:0]};
			e.len  = 3'd1;
		end else if (cp < LIMIT_TWO) begin
			e.b[0] = LEAD_TWO | {3'b000, cp[10:6]};
			e.b[1] = CONT_MARK | {2'b00, cp[5:0] & CONT_MASK};
			e.len  = 3'd2;
		end else if (cp < LIMIT_THREE) begin
			e.b[0] = LEAD_THREE | {4'h0, cp[15:12]};
			e.b[1] = CONT_MARK | {2'b00, cp[11:6] & CONT_MASK};
			e.b[2] = CONT_MARK | {2'b00, cp[5:0] & CONT_MASK};
			e.len  = 3'd3;
		end else begin
			e.b[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
			e.b[1] = CONT_MARK | {2'b00, cp[17:12] & CONT_MASK};
			e.b[2] = CONT_MARK | {2'b00, cp[11:6] & CONT_MASK};
			e.b[3] = CONT_MARK | {2'b00, cp[5:0] & CONT_MASK};
			e.len  = 3'd4;
		end
		return e;
	endfunction

endpackage

FILE: hdl/u16u8_decode.sv
module u16u8_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  u16u8_pkg::in_word_t in_word,
	input  logic                byte_order,
	output logic                run_valid,
	output u16u8_pkg::run_t     run,
	input  logic                run_free
);
	import u16u8_pkg::*;

	logic        valid_s1;
	in_word_t    word_s1;
	logic [7:0]  first_q;
	logic        have_first_q;
	logic [9:0]  held_q;
	logic        have_held_q;

	logic [15:0] wc;
	logic        is_low;
	logic        is_high;
	logic        p0_en;
	logic        p1_en;
	logic [20:0] p0_cp;
	logic [20:0] p1_cp;
	logic        held_nx;
	logic [9:0]  held_bits_nx;
	enc_t        e0;
	enc_t        e1;
	logic [2:0]  j;
	logic        emits;
	logic        adv;
	logic        take;

	// pair bytes into a code unit and pick at most two code points to emit
	always_comb begin
		wc           = byte_order ? {first_q, word_s1.byte_value}
		                          : {word_s1.byte_value, first_q};
		is_low       = (wc >= LOW_SUR_FIRST) && (wc <= LOW_SUR_LAST);
		is_high      = (wc >= HIGH_SUR_FIRST) && (wc <= HIGH_SUR_LAST);
		p0_en        = 1'b0;
		p1_en        = 1'b0;
		p0_cp        = '0;
		p1_cp        = '0;
		held_nx      = have_held_q;
		held_bits_nx = held_q;
		if (have_first_q) begin
			if (have_held_q && is_low) begin
				p0_en   = 1'b1;
				p0_cp   = SUPP_BASE + {1'b0, held_q, wc[9:0] & SUR_BITS_MASK};
				held_nx = 1'b0;
			end else begin
				if (have_held_q) begin
					p0_en = 1'b1;
					p0_cp = {5'b00000, HIGH_SUR_FIRST | {6'b000000, held_q}};
				end
				if (is_high) begin
					held_nx      = 1'b1;
					held_bits_nx = wc[9:0] & SUR_BITS_MASK;
				end else begin
					held_nx = 1'b0;
					p1_en   = 1'b1;
					p1_cp   = {5'b00000, wc};
				end
			end
		end
		// end of stream flushes a surrogate still held
		if (word_s1.end_of_stream && held_nx) begin
			p1_en = 1'b1;
			p1_cp = {5'b00000, HIGH_SUR_FIRST | {6'b000000, held_bits_nx}};
		end
	end

	// encode and pack both points into one run
	always_comb begin
		e0 = encode_cp(p0_cp);
		e1 = encode_cp(p1_cp);
		if (!p0_en) e0.len = 3'd0;
		if (!p1_en) e1.len = 3'd0;
		run.b = '0;
		for (int i = 0; i < RUN_MAX; i++) begin
			j = 3'(i) - e0.len;
			if (3'(i) < e0.len) begin
				run.b[i] = e0.b[2'(i)];
			end else if (j < e1.len) begin
				run.b[i] = e1.b[j[1:0]];
			end
		end
		run.eos  = word_s1.end_of_stream;
		run.data = (e0.len != 3'd0) || (e1.len != 3'd0);
		run.cnt  = run.data ? (e0.len + e1.len) : 3'd1;
	end

	assign emits     = run.data || word_s1.end_of_stream;
	assign run_valid = valid_s1 && emits;
	assign adv       = valid_s1 && (!emits || run_free);
	assign in_stall  = valid_s1 && !adv;
	assign take      = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1 <= in_word;
		end
	end

	// pairing and surrogate state, updated as a word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q      <= '0;
			have_first_q <= 1'b0;
			held_q       <= '0;
			have_held_q  <= 1'b0;
		end else if (adv) begin
			if (word_s1.end_of_stream) begin
				first_q      <= '0;
				have_first_q <= 1'b0;
				held_q       <= '0;
				have_held_q  <= 1'b0;
			end else if (!have_first_q) begin
				first_q      <= word_s1.byte_value;
				have_first_q <= 1'b1;
			end else begin
				first_q      <= '0;
				have_first_q <= 1'b0;
				held_q       <= held_nx ? held_bits_nx : 10'd0;
				have_held_q  <= held_nx;
			end
		end
	end

	a_stall_holds_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(word_s1))
		else $error("input register changed while stalled");

	a_run_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid |-> run.cnt != 3'd0 && run.cnt <= 3'(RUN_MAX))
		else $error("run length out of range");

	a_marker_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && !run.data |-> run.eos)
		else $error("empty run without end of stream");

endmodule

FILE: hdl/u16u8_serial.sv
module u16u8_serial (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 run_valid,
	input  u16u8_pkg::run_t      run,
	output logic                 run_free,
	output logic                 out_valid,
	input  logic                 out_stall,
	output u16u8_pkg::out_word_t out_word
);
	import u16u8_pkg::*;

	logic       valid_q;
	run_t       run_q;
	logic [2:0] idx_q;
	logic       last;
	logic       take;
	logic       load;

	assign last     = (idx_q == run_q.cnt - 3'd1);
	assign take     = valid_q && !out_stall;
	assign run_free = !valid_q || (take && last);
	assign load     = run_valid && run_free;

	// result register: one byte of the held run per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (take) begin
			if (last) begin
				valid_q <= 1'b0;
				idx_q   <= '0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q <= run;
		end
	end

	assign out_valid            = valid_q;
	assign out_word.out_byte    = (idx_q < 3'(RUN_MAX)) ? run_q.b[idx_q] : 8'h00;
	assign out_word.byte_valid  = run_q.data;
	assign out_word.last_of_run = last;
	assign out_word.stream_done = last && run_q.eos;

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> idx_q < run_q.cnt)
		else $error("byte index beyond run");

	a_stall_holds_pos: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_stall |=> valid_q && $stable(idx_q))
		else $error("output position moved while stalled");

	a_step_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		take && !last |=> valid_q && idx_q == $past(idx_q) + 3'd1)
		else $error("output position did not step");

endmodule

FILE: hdl/utf16_to_utf8_transcoder_unit.sv
// UTF-16 to UTF-8 transcoder. Raw UTF-16 bytes enter one word per cycle while
// in_stall is low, paired into code units in the order set by byte_order (0
// little-endian, 1 big-endian, sampled as the second byte of a unit is decoded);
// surrogate pairs are joined and unpaired surrogates come out as 3-byte
// sequences. A word is held in an input register, decoded in one pass into a
// run of 0 to 6 UTF-8 bytes and loaded into a result register, which hands out
// one byte per cycle while out_stall is low; the first byte is on the output
// once its run is loaded, which waits while the previous run is still being
// handed out. The byte-wide output is the limit: a word that completes a code
// point occupies the output while its result bytes are handed out, and a word
// that completes nothing passes alongside the output of the previous run. Thus
// 1-, 2- and 4-byte sequences run at one input byte per cycle while the output
// is not stalled; 3-byte sequences and an unpaired high surrogate followed by a
// 3-byte unit run slower, held by their result bytes. An end_of_stream word
// flushes a held high surrogate, drops an odd byte and always yields at least
// one word with stream_done set.
module utf16_to_utf8_transcoder_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  u16u8_pkg::in_word_t  in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output u16u8_pkg::out_word_t out_word,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata
);
	import u16u8_pkg::*;

	logic byte_order_q;
	logic run_valid;
	run_t run;
	logic run_free;

	// byte order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_order_q <= 1'b0;
		end else if (cfg_we) begin
			byte_order_q <= cfg_wdata;
		end
	end

	u16u8_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_word    (in_word),
		.byte_order (byte_order_q),
		.run_valid  (run_valid),
		.run        (run),
		.run_free   (run_free)
	);

	u16u8_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.run_valid (run_valid),
		.run       (run),
		.run_free  (run_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

FILE: verif/tb_utf16_to_utf8_transcoder_unit.sv
`timescale 1ns / 100ps

module tb_utf16_to_utf8_transcoder_unit;
	import u16u8_pkg::*;

	localparam int unsigned MAX_GAP       = 12;
	localparam int unsigned LONG_HOLD     = 300;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned TAIL_CYCLES   = 8;
	localparam int unsigned RANDOM_WORDS  = 296;
	localparam int unsigned SEGMENTS      = 8;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_word_t  in_word   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_word;
	logic      cfg_we    = 1'b0;
	logic      cfg_wdata = 1'b0;

	// transcoder model state
	logic       pred_byte_order = 1'b0;
	logic [7:0] pred_first_byte = '0;
	logic       pred_have_first = 1'b0;
	logic [9:0] pred_high_bits  = '0;
	logic       pred_have_high  = 1'b0;
	logic [7:0] utf8_run[$];
	out_word_t  utf8_expected_q[$];

	// run control and tallies
	bit          source_idle    = 1'b1;
	bit          sink_idle      = 1'b1;
	bit          sink_long_hold = 1'b0;
	int unsigned fail_count     = 0;
	int unsigned words_in       = 0;
	int unsigned words_out      = 0;
	int unsigned streams_ended  = 0;
	int unsigned order_writes   = 0;
	int unsigned idle_cycles    = 0;

	utf16_to_utf8_transcoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// UTF-8 encoding of one code point into the current run
	function void encode_code_point(input logic [20:0] cp);
		if (cp < LIMIT_ONE) begin
			utf8_run.push_back(cp[7:0]);
		end else if (cp < LIMIT_TWO) begin
			utf8_run.push_back(LEAD_TWO | {3'b000, cp[10:6]});
			utf8_run.push_back(CONT_MARK | {2'b00, cp[5:0]});
		end else if (cp < LIMIT_THREE) begin
			utf8_run.push_back(LEAD_THREE | {4'h0, cp[15:12]});
			utf8_run.push_back(CONT_MARK | {2'b00, cp[11:6]});
			utf8_run.push_back(CONT_MARK | {2'b00, cp[5:0]});
		end else begin
			utf8_run.push_back(LEAD_FOUR | {5'b00000, cp[20:18]});
			utf8_run.push_back(CONT_MARK | {2'b00, cp[17:12]});
			utf8_run.push_back(CONT_MARK | {2'b00, cp[11:6]});
			utf8_run.push_back(CONT_MARK | {2'b00, cp[5:0]});
		end
	endfunction

	// an unpaired high surrogate goes out as three bytes
	function void flush_held_high();
		if (pred_have_high) begin
			encode_code_point({5'b00000, HIGH_SUR_FIRST | {6'b000000, pred_high_bits}});
			pred_have_high = 1'b0;
			pred_high_bits = '0;
		end
	endfunction

	// surrogate pairing of one complete code unit
	function void take_code_unit(input logic [15:0] unit);
		if (pred_have_high) begin
			if (unit >= LOW_SUR_FIRST && unit <= LOW_SUR_LAST) begin
				encode_code_point(SUPP_BASE + {1'b0, pred_high_bits, unit[9:0]});
				pred_have_high = 1'b0;
				pred_high_bits = '0;
				return;
			end
			flush_held_high();
		end
		if (unit >= HIGH_SUR_FIRST && unit <= HIGH_SUR_LAST) begin
			pred_high_bits = unit[9:0];
			pred_have_high = 1'b1;
		end else begin
			encode_code_point({5'b00000, unit});
		end
	endfunction

	// expected output words for one accepted input word
	function void transcode_word(input in_word_t w);
		logic [15:0] unit;
		out_word_t   r;
		int          n;
		int          k;
		utf8_run.delete();
		if (!pred_have_first) begin
			pred_first_byte = w.byte_value;
			pred_have_first = 1'b1;
		end else begin
			unit = pred_byte_order ? {pred_first_byte, w.byte_value}
				: {w.byte_value, pred_first_byte};
			pred_have_first = 1'b0;
			pred_first_byte = '0;
			take_code_unit(unit);
		end
		if (w.end_of_stream) begin
			flush_held_high();
			pred_have_first = 1'b0;
			pred_first_byte = '0;
			streams_ended++;
			if (utf8_run.size() == 0) begin
				r.out_byte    = '0;
				r.byte_valid  = 1'b0;
				r.last_of_run = 1'b1;
				r.stream_done = 1'b1;
				utf8_expected_q.push_back(r);
				return;
			end
		end
		n = utf8_run.size();
		for (k = 0; k < n; k++) begin
			r.out_byte    = utf8_run[k];
			r.byte_valid  = 1'b1;
			r.last_of_run = (k == n - 1);
			r.stream_done = (k == n - 1) && w.end_of_stream;
			utf8_expected_q.push_back(r);
		end
	endfunction

	function void check_field(input string name, input logic [7:0] want_v,
		input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
			fail_count++;
		end
	endfunction

	// one input word, with a random gap ahead of it when idling is on
	task send_word(input logic [7:0] b, input logic eos);
		int unsigned gap;
		gap = source_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= '{byte_value: b, end_of_stream: eos};
		do @(posedge clk); while (in_stall !== 1'b0);
		transcode_word(in_word);
		words_in++;
	endtask

	// a 16-bit code unit as two words in the current byte order
	task send_unit(input logic [15:0] unit, input bit random_end);
		logic [7:0] lead;
		logic [7:0] trail;
		lead  = pred_byte_order ? unit[15:8] : unit[7:0];
		trail = pred_byte_order ? unit[7:0] : unit[15:8];
		send_word(lead, random_end && ($urandom_range(0, 39) == 0));
		send_word(trail, random_end && ($urandom_range(0, 39) == 0));
	endtask

	// mostly well-formed text, with unpaired surrogates and stray bytes mixed in
	task send_random_unit();
		int unsigned pick;
		logic [15:0] unit;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			send_unit(16'($urandom_range(0, 16'h007F)), 1'b1);
		end else if (pick < 45) begin
			send_unit(16'($urandom_range(16'h0080, 16'h07FF)), 1'b1);
		end else if (pick < 60) begin
			unit = 16'($urandom_range(16'h0800, 16'hF7FF));
			if (unit >= HIGH_SUR_FIRST)
				unit = unit + 16'h0800;
			send_unit(unit, 1'b1);
		end else if (pick < 78) begin
			send_unit(16'($urandom_range(HIGH_SUR_FIRST, HIGH_SUR_LAST)), 1'b1);
			send_unit(16'($urandom_range(LOW_SUR_FIRST, LOW_SUR_LAST)), 1'b1);
		end else if (pick < 84) begin
			send_unit(16'($urandom_range(HIGH_SUR_FIRST, HIGH_SUR_LAST)), 1'b1);
		end else if (pick < 89) begin
			send_unit(16'($urandom_range(LOW_SUR_FIRST, LOW_SUR_LAST)), 1'b1);
		end else if (pick < 95) begin
			send_unit(16'($urandom_range(0, 16'hFFFF)), 1'b1);
		end else begin
			send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
		end
	endtask

	// wait until every expected word is out and the pipeline has settled
	task drain();
		in_valid <= 1'b0;
		while (utf8_expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task set_byte_order(input logic order);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= order;
		@(posedge clk);
		cfg_we    <= 1'b0;
		pred_byte_order = order;
		order_writes++;
	endtask

	// 1-, 2- and 3-byte boundaries, little-endian
	task test_unit_ranges();
		set_byte_order(1'b0);
		send_unit(16'h007F, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'hFFFF, 1'b0);
	endtask

	// largest pair, lone low, high followed by a 3-byte unit, big-endian
	task test_surrogates();
		set_byte_order(1'b1);
		send_unit(16'hDBFF, 1'b0);
		send_unit(16'hDFFF, 1'b0);
		send_unit(16'hDC00, 1'b0);
		send_unit(16'hD800, 1'b0);
		send_unit(16'h0800, 1'b0);
	endtask

	// held high flushed with an odd byte dropped, then a bare end marker
	task test_end_of_stream();
		send_unit(16'hD800, 1'b0);
		send_word(8'h41, 1'b1);
		send_word(8'h00, 1'b1);
	endtask

	// byte order taken when the second byte of a unit arrives
	task test_order_switch_mid_unit();
		send_word(8'h41, 1'b0);
		set_byte_order(1'b0);
		send_word(8'h00, 1'b0);
	endtask

	// sink holds off while the source keeps offering words back to back
	task test_backpressure();
		drain();
		source_idle    = 1'b0;
		sink_idle      = 1'b0;
		sink_long_hold = 1'b1;
		repeat (60) send_random_unit();
		drain();
	endtask

	// random streams over several byte orders and idling mixes
	task test_random_streams();
		int unsigned seg;
		int unsigned target;
		for (seg = 0; seg < SEGMENTS; seg++) begin
			set_byte_order(1'($urandom_range(0, 1)));
			source_idle = (seg != 0) && (seg % 3 != 2);
			sink_idle   = (seg != 0) && (seg % 4 != 3);
			target = words_in + RANDOM_WORDS / SEGMENTS;
			while (words_in < target) send_random_unit();
		end
	endtask

	// output sink: random stall before each word, one long hold on request
	initial begin : utf8_sink
		int unsigned gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_long_hold) begin
				sink_long_hold = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			gap = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// compare each output word with the oldest expectation
	always @(posedge clk) begin : utf8_check
		out_word_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			words_out++;
			if (utf8_expected_q.size() == 0) begin
				$error("unexpected output word 0x%0h", out_word);
				fail_count++;
			end else begin
				want = utf8_expected_q.pop_front();
				check_field("out_byte", want.out_byte, out_word.out_byte);
				check_field("byte_valid", 8'(want.byte_valid),
					8'(out_word.byte_valid));
				check_field("last_of_run", 8'(want.last_of_run),
					8'(out_word.last_of_run));
				check_field("stream_done", 8'(want.stream_done),
					8'(out_word.stream_done));
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("utf16_to_utf8_transcoder_unit regression: fail");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unit_ranges();
		test_surrogates();
		test_end_of_stream();
		test_order_switch_mid_unit();
		test_backpressure();
		test_random_streams();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d UTF-16 words in, %0d UTF-8 words out, %0d stream ends",
			words_in, words_out, streams_ended);
		$display("%0d byte order writes, one long output hold, %0d failures",
			order_writes, fail_count);
		if (fail_count == 0) begin
			$display("utf16_to_utf8_transcoder_unit regression: pass");
		end else begin
			$display("utf16_to_utf8_transcoder_unit regression: fail");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/u16u8_pkg.sv
hdl/u16u8_decode.sv
hdl/u16u8_serial.sv
hdl/utf16_to_utf8_transcoder_unit.sv
verif/tb_utf16_to_utf8_transcoder_unit.sv
